// File: design/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the sorted rank table.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

   localparam int TableDepthDefault = 64;
   localparam int MaxResults        = 64;
   localparam int RankMin           = 1;
   localparam int RankMax           = 4;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_RANK  = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_ENTRY     = 3'd4,
      ST_NOTHING   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_DELETE = 2'd1,
      FN_REPORT = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_INS_HEAD,
      S_DEL,
      S_REP
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [2:0]  rank;
      logic [11:0] year;
   } rec_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_new;
   } store_ctrl_type;

   typedef struct packed {
      logic key_ge;
      logic id_eq;
   } store_stat_type;

endpackage

`default_nettype wire

// File: design/srt_store.sv
// ----------------------------------------------------------------------------
// srt_store
// Entry memory with registered read, plus the shared key and identifier
// compare against the transaction's record.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_store #(
   parameter int  TableDepth = srt_pkg::TableDepthDefault,
   localparam int AddrW      = $clog2(TableDepth)
) (
   input  wire                          clock,
   input  wire srt_pkg::store_ctrl_type ctrl,
   input  wire [AddrW-1:0]              rd_addr,
   input  wire [AddrW-1:0]              wr_addr,
   input  wire srt_pkg::rec_type        new_rec,
   output srt_pkg::rec_type             rd_rec,
   output srt_pkg::store_stat_type      stat
);
   import srt_pkg::*;

   rec_type mem [TableDepth];
   rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= ctrl.wr_new ? new_rec : rd_rec_ff;
      end
      if (ctrl.rd_en) begin
         rd_rec_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      stat.key_ge = {rd_rec_ff.rank, rd_rec_ff.year} >= {new_rec.rank, new_rec.year};
      stat.id_eq  = (rd_rec_ff.id == new_rec.id);
   end

   assign rd_rec = rd_rec_ff;

endmodule

`default_nettype wire

// File: design/sorted_rank_table_top.sv
// ----------------------------------------------------------------------------
// sorted_rank_table_top
// Ordered table of (id, rank, year) records with insert, delete and report.
// Bad rank, full, empty-table and nothing-to-report cases answer in the cycle
//   after start; insert walks down from the last entry, shifting entries up,
//   delete walks every entry from the first, report walks down from the last.
// Throughput: one transaction at a time, the memory walked one entry per
//   cycle; busy is high during the walk. Results cannot stall.
// Reset: synchronous; empties the table, memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_rank_table_top #(
   parameter int  TableDepth = srt_pkg::TableDepthDefault,
   localparam int AddrW      = $clog2(TableDepth),
   localparam int CountW     = $clog2(TableDepth + 1)
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_func,
   input  wire  [31:0] req_record_id,
   input  wire  [2:0]  req_rank_code,
   input  wire  [11:0] req_rank_year,
   input  wire  [6:0]  req_report_count,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_out_id,
   output logic [2:0]  rsp_out_rank,
   output logic [11:0] rsp_out_year,
   output logic        rsp_last
);
   import srt_pkg::*;

   localparam int NumW = (CountW > 7) ? CountW : 7;

   state_type        state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [AddrW-1:0] proc_ff, proc_in;
   logic [6:0]       rem_ff, rem_in;
   logic             found_ff, found_in;
   rec_type          new_rec_ff, new_rec_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   status_type       rsp_status_ff, rsp_status_in;
   rec_type          rsp_rec_ff, rsp_rec_in;
   logic             rsp_last_ff, rsp_last_in;

   store_ctrl_type   ctrl;
   store_stat_type   stat;
   logic [AddrW-1:0] rd_addr, wr_addr;
   rec_type          rd_rec, store_new;

   logic             accept;
   rec_type          req_rec;
   logic             bad_rank, table_full, table_empty;
   logic [AddrW-1:0] last_idx;
   logic [6:0]       rep_cap, rep_n;

   srt_store #(.TableDepth(TableDepth)) u_store (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .new_rec (store_new),
      .rd_rec  (rd_rec),
      .stat    (stat)
   );

   // request decode
   always_comb begin
      accept      = start && (state_ff == S_IDLE);
      req_rec     = '{id: req_record_id, rank: req_rank_code, year: req_rank_year};
      bad_rank    = (req_rank_code < 3'(RankMin)) || (req_rank_code > 3'(RankMax));
      table_full  = (count_ff == CountW'(TableDepth));
      table_empty = (count_ff == '0);
      last_idx    = AddrW'(count_ff - CountW'(1));
      rep_cap     = (req_report_count > 7'(MaxResults)) ? 7'(MaxResults) : req_report_count;
      rep_n       = (NumW'(rep_cap) > NumW'(count_ff)) ? 7'(count_ff) : rep_cap;
      store_new   = (state_ff == S_IDLE) ? req_rec : new_rec_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (func_type'(req_func))
                  FN_INSERT: begin
                     if (!bad_rank && !table_full && !table_empty) begin
                        state_in = S_INS;
                     end
                  end
                  FN_DELETE: begin
                     if (!table_empty) begin
                        state_in = S_DEL;
                     end
                  end
                  FN_REPORT: begin
                     if (rep_n != '0) begin
                        state_in = S_REP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS: begin
            if (!stat.key_ge) begin
               state_in = S_IDLE;
            end else if (proc_ff == '0) begin
               state_in = S_INS_HEAD;
            end
         end
         S_INS_HEAD: state_in = S_IDLE;
         S_DEL: begin
            if (proc_ff == last_idx) begin
               state_in = S_IDLE;
            end
         end
         S_REP: begin
            if (rem_ff == 7'd1) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      ctrl          = '0;
      rd_addr       = proc_ff;
      wr_addr       = proc_ff;
      count_in      = count_ff;
      proc_in       = proc_ff;
      rem_in        = rem_ff;
      found_in      = found_ff;
      new_rec_in    = new_rec_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_rec_in    = '0;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               new_rec_in = req_rec;
               found_in   = 1'b0;
               case (func_type'(req_func))
                  FN_INSERT: begin
                     if (bad_rank) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_BAD_RANK;
                     end else if (table_full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (table_empty) begin
                        ctrl.wr_en    = 1'b1;
                        ctrl.wr_new   = 1'b1;
                        wr_addr       = '0;
                        count_in      = count_ff + CountW'(1);
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_OK;
                     end else begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = last_idx;
                        proc_in    = last_idx;
                     end
                  end
                  FN_DELETE: begin
                     if (table_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = '0;
                        proc_in    = '0;
                     end
                  end
                  FN_REPORT: begin
                     if (rep_n == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOTHING;
                     end else begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = last_idx;
                        proc_in    = last_idx;
                        rem_in     = rep_n;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INS: begin
            ctrl.wr_en = 1'b1;
            wr_addr    = proc_ff + AddrW'(1);
            if (stat.key_ge) begin
               ctrl.wr_new = 1'b0;
               if (proc_ff != '0) begin
                  ctrl.rd_en = 1'b1;
                  rd_addr    = proc_ff - AddrW'(1);
                  proc_in    = proc_ff - AddrW'(1);
               end
            end else begin
               ctrl.wr_new   = 1'b1;
               count_in      = count_ff + CountW'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
            end
         end
         S_INS_HEAD: begin
            ctrl.wr_en    = 1'b1;
            ctrl.wr_new   = 1'b1;
            wr_addr       = '0;
            count_in      = count_ff + CountW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
         end
         S_DEL: begin
            if (found_ff) begin
               ctrl.wr_en = 1'b1;
               wr_addr    = proc_ff - AddrW'(1);
            end else if (stat.id_eq) begin
               found_in = 1'b1;
            end
            if (proc_ff == last_idx) begin
               rsp_strobe_in = 1'b1;
               if (found_ff || stat.id_eq) begin
                  count_in      = count_ff - CountW'(1);
                  rsp_status_in = ST_OK;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end else begin
               ctrl.rd_en = 1'b1;
               rd_addr    = proc_ff + AddrW'(1);
               proc_in    = proc_ff + AddrW'(1);
            end
         end
         S_REP: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_ENTRY;
            rsp_rec_in    = rd_rec;
            rsp_last_in   = (rem_ff == 7'd1);
            if (rem_ff != 7'd1) begin
               ctrl.rd_en = 1'b1;
               rd_addr    = proc_ff - AddrW'(1);
               proc_in    = proc_ff - AddrW'(1);
               rem_in     = rem_ff - 7'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff       <= proc_in;
      rem_ff        <= rem_in;
      new_rec_ff    <= new_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_id   = rsp_rec_ff.id;
   assign rsp_out_rank = rsp_rec_ff.rank;
   assign rsp_out_year = rsp_rec_ff.year;
   assign rsp_last     = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(TableDepth))
      else $error("entry count above table depth");

   a_write_when_active: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |-> (state_ff != S_IDLE) || accept)
      else $error("memory write outside a transaction");

   a_partial_from_report: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_last_ff |-> $past(state_ff == S_REP))
      else $error("non-final result outside a report");

   a_report_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_last_ff |-> busy)
      else $error("report ended before its final result");

   a_head_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_HEAD |=> count_ff == $past(count_ff) + CountW'(1))
      else $error("head insert did not grow the table");

endmodule

`default_nettype wire
